// ===== src/oats_pkg.sv =====
// ----------------------------------------------------------------------------
// oats_pkg
// shared types and constants of the ordered array table with sort
// ----------------------------------------------------------------------------
package oats_pkg;

   localparam int DEF_CAPACITY    = 256;
   localparam int DEF_VALUE_WIDTH = 32;

   // fixed field widths of the request and response items
   localparam int ACTION_W   = 3;
   localparam int IN_VALUE_W = 32;
   localparam int IN_POS_W   = 8;
   localparam int STATUS_W   = 2;
   localparam int FOUND_W    = 8;
   localparam int RD_W       = 32;
   localparam int COUNT_W    = 9;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 56;

   typedef enum logic [ACTION_W-1:0] {
      ACT_APPEND = 3'd0,
      ACT_INSERT = 3'd1,
      ACT_DELETE = 3'd2,
      ACT_FIND   = 3'd3,
      ACT_READ   = 3'd4,
      ACT_SORT   = 3'd5
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_FULL    = 2'd1,
      STAT_RANGE   = 2'd2,
      STAT_MISSING = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE,
      CELL_SORT
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        phase;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SORT,
      S_DONE
   } state_type;

endpackage

// ===== src/oats_cell.sv =====
// ----------------------------------------------------------------------------
// oats_cell
// one table entry: shifts with its neighbors, rotates and does odd-even swaps
// ----------------------------------------------------------------------------
module oats_cell #(
   parameter int VALUE_WIDTH = oats_pkg::DEF_VALUE_WIDTH,
   parameter int INDEX       = 0,
   parameter int POS_WIDTH   = 8
) (
   input  logic                   clock,
   input  oats_pkg::cell_ctl_type ctl,
   input  logic [POS_WIDTH-1:0]   pos,
   input  logic [POS_WIDTH-1:0]   right_pos,
   input  logic [VALUE_WIDTH-1:0] value,
   input  logic [VALUE_WIDTH-1:0] left_q,
   input  logic [VALUE_WIDTH-1:0] right_q,
   input  logic                   left_gt,
   output logic [VALUE_WIDTH-1:0] q,
   output logic                   gt
);
   import oats_pkg::*;

   localparam logic [POS_WIDTH-1:0] IDX    = POS_WIDTH'(INDEX);
   localparam logic                 PARITY = 1'(INDEX % 2);

   logic [VALUE_WIDTH-1:0] entry_ff;
   logic [VALUE_WIDTH-1:0] entry_in;
   logic                   lower_act;
   logic                   upper_act;

   assign q  = entry_ff;
   assign gt = $signed(entry_ff) > $signed(right_q);

   // this cell is the low or the high half of a pair compared in this phase
   assign lower_act = (PARITY == ctl.phase) && (IDX >= pos) && (IDX < right_pos);
   assign upper_act = (INDEX != 0) && (PARITY != ctl.phase) && (IDX > pos) &&
                      (IDX <= right_pos);

   always_comb begin
      entry_in = entry_ff;
      unique case (ctl.op)
         CELL_HOLD: begin
            entry_in = entry_ff;
         end
         CELL_INSERT: begin
            if (IDX > pos) begin
               entry_in = left_q;
            end else if (IDX == pos) begin
               entry_in = value;
            end
         end
         CELL_DELETE: begin
            if (IDX >= pos) begin
               entry_in = right_q;
            end
         end
         CELL_ROTATE: begin
            entry_in = right_q;
         end
         CELL_SORT: begin
            if (lower_act && gt) begin
               entry_in = right_q;
            end else if (upper_act && left_gt) begin
               entry_in = left_q;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== src/oats_ctrl.sv =====
// ----------------------------------------------------------------------------
// oats_ctrl
// request decode, fill count, scan and sort sequencing, response register
// ----------------------------------------------------------------------------
module oats_ctrl #(
   parameter int CAPACITY    = oats_pkg::DEF_CAPACITY,
   parameter int VALUE_WIDTH = oats_pkg::DEF_VALUE_WIDTH,
   parameter int POS_WIDTH   = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [oats_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic [oats_pkg::ACTION_W-1:0]        req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [oats_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic [VALUE_WIDTH-1:0]               head_q,
   output oats_pkg::cell_ctl_type               cell_ctl,
   output logic [POS_WIDTH-1:0]                 cell_pos,
   output logic [POS_WIDTH-1:0]                 cell_right,
   output logic [VALUE_WIDTH-1:0]               cell_value
);
   import oats_pkg::*;

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [IW-1:0] LAST_STEP = IW'(CAPACITY - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

   state_type              state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [IW-1:0]          step_ff, step_in;
   action_type             act_ff, act_in;
   logic [VALUE_WIDTH-1:0] key_ff, key_in;
   logic [POS_WIDTH-1:0]   pos_ff, pos_in;
   logic [POS_WIDTH-1:0]   right_ff, right_in;
   status_type             stat_ff, stat_in;
   logic [FOUND_W-1:0]     found_ff, found_in;
   logic [RD_W-1:0]        rd_ff, rd_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic                   accept;
   action_type             req_act;
   logic signed [IN_VALUE_W-1:0] req_value_s;
   logic [VALUE_WIDTH-1:0] req_value;
   logic [POS_WIDTH-1:0]   req_pos;
   logic [POS_WIDTH-1:0]   req_right;
   logic [POS_WIDTH-1:0]   count_ext;
   logic [POS_WIDTH-1:0]   step_ext;
   logic                   is_full;
   logic                   slot_free;

   assign req_tready  = (state_ff == S_IDLE);
   assign accept      = req_tvalid && req_tready;
   assign req_act     = action_type'(req_tuser);
   assign req_value_s = req_tdata[IN_VALUE_W-1:0];
   assign req_value   = VALUE_WIDTH'(req_value_s);
   assign req_pos     = POS_WIDTH'(req_tdata[IN_VALUE_W +: IN_POS_W]);
   assign req_right   = POS_WIDTH'(req_tdata[IN_VALUE_W+IN_POS_W +: IN_POS_W]);
   assign count_ext   = POS_WIDTH'(count_ff);
   assign step_ext    = POS_WIDTH'(step_ff);
   assign is_full     = (count_ff == FULL_COUNT);
   assign slot_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               priority case (req_act)
                  ACT_FIND: state_in = S_SCAN;
                  ACT_READ: state_in = (req_pos < count_ext) ? S_SCAN : S_DONE;
                  ACT_SORT: begin
                     state_in = (req_right < count_ext && req_pos < req_right) ?
                                S_SORT : S_DONE;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_SCAN, S_SORT: begin
            if (step_ff == LAST_STEP) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      cell_ctl.op    = CELL_HOLD;
      cell_ctl.phase = step_ff[0];
      cell_pos       = pos_ff;
      cell_right     = right_ff;
      cell_value     = key_ff;
      count_in       = count_ff;
      step_in        = step_ff;
      act_in         = act_ff;
      key_in         = key_ff;
      pos_in         = pos_ff;
      right_in       = right_ff;
      stat_in        = stat_ff;
      found_in       = found_ff;
      rd_in          = rd_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               act_in     = req_act;
               key_in     = req_value;
               pos_in     = req_pos;
               right_in   = req_right;
               step_in    = '0;
               stat_in    = STAT_OK;
               found_in   = '0;
               rd_in      = '0;
               cell_value = req_value;
               unique case (req_act)
                  ACT_APPEND: begin
                     if (is_full) begin
                        stat_in = STAT_FULL;
                     end else begin
                        cell_ctl.op = CELL_INSERT;
                        cell_pos    = count_ext;
                        count_in    = count_ff + CW'(1);
                     end
                  end
                  ACT_INSERT: begin
                     if (is_full) begin
                        stat_in = STAT_FULL;
                     end else if (req_pos > count_ext) begin
                        stat_in = STAT_RANGE;
                     end else begin
                        cell_ctl.op = CELL_INSERT;
                        cell_pos    = req_pos;
                        count_in    = count_ff + CW'(1);
                     end
                  end
                  ACT_DELETE: begin
                     if (req_pos >= count_ext) begin
                        stat_in = STAT_RANGE;
                     end else begin
                        cell_ctl.op = CELL_DELETE;
                        cell_pos    = req_pos;
                        count_in    = count_ff - CW'(1);
                     end
                  end
                  ACT_FIND: begin
                     stat_in = STAT_MISSING;
                  end
                  ACT_READ: begin
                     if (req_pos >= count_ext) begin
                        stat_in = STAT_RANGE;
                     end
                  end
                  ACT_SORT: begin
                     if (req_right >= count_ext) begin
                        stat_in = STAT_RANGE;
                     end
                  end
                  default: begin
                     stat_in = STAT_OK;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // the whole row rotates once; cell 0 shows entry step_ff each cycle
            cell_ctl.op = CELL_ROTATE;
            step_in     = step_ff + IW'(1);
            if (act_ff == ACT_FIND && stat_ff == STAT_MISSING &&
                step_ext < count_ext && head_q == key_ff) begin
               stat_in  = STAT_OK;
               found_in = FOUND_W'(step_ff);
            end
            if (act_ff == ACT_READ && step_ext == pos_ff) begin
               rd_in = RD_W'(head_q);
            end
         end
         S_SORT: begin
            // odd-even transposition, one phase a cycle
            cell_ctl.op = CELL_SORT;
            step_in     = step_ff + IW'(1);
         end
         S_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({COUNT_W'(count_ff), rd_ff, found_ff,
                                           stat_ff});
            end
         end
         default: begin
            cell_ctl.op = CELL_HOLD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      act_ff      <= act_in;
      key_ff      <= key_in;
      pos_ff      <= pos_in;
      right_ff    <= right_in;
      stat_ff     <= stat_in;
      found_ff    <= found_in;
      rd_ff       <= rd_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== src/ordered_array_table_with_sort_core.sv =====
// ----------------------------------------------------------------------------
// ordered_array_table_with_sort_core
// dense table of signed words held in a row of cells, with find and sort
// ----------------------------------------------------------------------------
// Requests arrive on req_*: req_tuser carries the action (append, insert,
// delete, find, read, sort range), req_tdata the value, position and right
// end. Each request gives exactly one response on rsp_* with status, found
// position, read value and the entry count after the action.
// One request is in work at a time. Append, insert, delete, errors, unknown
// actions and sorts of one entry or of a reversed range finish in the accept
// cycle. Find and read rotate the whole row of CAPACITY cells once past
// cell 0, and a sort of two or more entries runs CAPACITY odd-even
// transposition phases. req_tready returns as the response enters the
// output register.
// Reset clears the entry count and the response valid flag; the entries
// themselves are not cleared and only positions below the count are read.
// While rsp_tready is low the response is held and a finished request
// waits for the output register before req_tready returns.
module ordered_array_table_with_sort_core #(
   parameter int CAPACITY    = oats_pkg::DEF_CAPACITY,
   parameter int VALUE_WIDTH = oats_pkg::DEF_VALUE_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // value [31:0], position [39:32], right_end [47:40]
   input  logic [oats_pkg::REQ_DATA_W-1:0] req_tdata,
   // action [2:0]
   input  logic [oats_pkg::ACTION_W-1:0]   req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status [1:0], found_position [9:2], read_value [41:10],
   // entry_count [50:42], zero [55:51]
   output logic [oats_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import oats_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > IN_POS_W) ? CW : IN_POS_W;

   cell_ctl_type           cell_ctl;
   logic [PW-1:0]          cell_pos;
   logic [PW-1:0]          cell_right;
   logic [VALUE_WIDTH-1:0] cell_value;
   logic [VALUE_WIDTH-1:0] cell_q [CAPACITY];
   logic                   cell_gt [CAPACITY];

   oats_ctrl #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH),
      .POS_WIDTH   (PW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .head_q     (cell_q[0]),
      .cell_ctl   (cell_ctl),
      .cell_pos   (cell_pos),
      .cell_right (cell_right),
      .cell_value (cell_value)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      oats_cell #(
         .VALUE_WIDTH (VALUE_WIDTH),
         .INDEX       (i),
         .POS_WIDTH   (PW)
      ) u_cell (
         .clock     (clock),
         .ctl       (cell_ctl),
         .pos       (cell_pos),
         .right_pos (cell_right),
         .value     (cell_value),
         .left_q    (cell_q[(i + CAPACITY - 1) % CAPACITY]),
         .right_q   (cell_q[(i + 1) % CAPACITY]),
         .left_gt   (cell_gt[(i + CAPACITY - 1) % CAPACITY]),
         .q         (cell_q[i]),
         .gt        (cell_gt[i])
      );
   end

endmodule

// ===== src/oats_checker.sv =====
// ----------------------------------------------------------------------------
// oats_checker
// port-level checks of the ordered array table, bound to the top level
// ----------------------------------------------------------------------------
module oats_checker #(
   parameter int CAPACITY = oats_pkg::DEF_CAPACITY
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [oats_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic [oats_pkg::ACTION_W-1:0]   req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [oats_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import oats_pkg::*;

   logic [STATUS_W-1:0] rsp_status;
   logic [FOUND_W-1:0]  rsp_found;
   logic [RD_W-1:0]     rsp_read;
   logic [COUNT_W-1:0]  rsp_count;
   logic                req_seen;

   assign rsp_status = rsp_tdata[STATUS_W-1:0];
   assign rsp_found  = rsp_tdata[STATUS_W +: FOUND_W];
   assign rsp_read   = rsp_tdata[STATUS_W+FOUND_W +: RD_W];
   assign rsp_count  = rsp_tdata[STATUS_W+FOUND_W+RD_W +: COUNT_W];
   assign req_seen   = (^req_tdata) | (^req_tuser) | 1'b1;

   // one request in work at a time
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_seen |=> !req_tready)
      else $error("request taken while another is in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // a failed request reports no position and no data
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status != STAT_OK |-> rsp_found == '0 && rsp_read == '0)
      else $error("failed request carries data");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == STAT_FULL |-> rsp_count == COUNT_W'(CAPACITY))
      else $error("full status with table not full");

endmodule

bind ordered_array_table_with_sort_core oats_checker #(
   .CAPACITY (CAPACITY)
) u_oats_checker (.*);
